// ===== sv/ookpcf_pkg.sv =====
// ----------------------------------------------------------------------------
// OOK pulse capture framer package
// Word types, mode and end-cause codes, register indexes, reset values and width bounds.
// ----------------------------------------------------------------------------
package ookpcf_pkg;

  // Item modes
  localparam logic [1:0] MODE_EDGE    = 2'd0;
  localparam logic [1:0] MODE_TCHECK  = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;
  localparam logic [1:0] MODE_READ    = 2'd3;

  // Frame end causes
  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_GAP     = 2'd1;
  localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;
  localparam logic [1:0] CAUSE_FULL    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_CAPTURE_ENABLE   = 2'd0;
  localparam logic [1:0] REG_NOISE_LIMIT_US   = 2'd1;
  localparam logic [1:0] REG_FRAME_GAP_US     = 2'd2;
  localparam logic [1:0] REG_MIN_FRAME_PULSES = 2'd3;

  // Configuration reset values
  localparam logic [15:0] NOISE_LIMIT_RESET = 16'd150;
  localparam logic [14:0] FRAME_GAP_RESET   = 15'd25000;
  localparam logic [9:0]  MIN_PULSES_RESET  = 10'd20;

  // Saturation bounds of a stored width
  localparam logic signed [16:0] WIDTH_MAX = 17'sd32767;
  localparam logic signed [16:0] WIDTH_MIN = -17'sd32768;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] time_us;
    logic        level;
    logic [8:0]  read_index;
  } in_word_t;

  typedef struct packed {
    logic               frame_ready;
    logic [9:0]         pulse_count;
    logic signed [15:0] read_value;
    logic [1:0]         end_cause;
    logic [31:0]        glitch_total;
    logic [31:0]        merge_total;
  } out_word_t;

endpackage

// ===== sv/ook_pulse_capture_framer.sv =====
// ----------------------------------------------------------------------------
// OOK pulse capture framer
// Turns receiver edges into a buffer of signed pulse widths and frames them.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one word per item:
//   an edge, a time check, a frame release or a read of one stored entry.
//   Output channel (out_valid / out_stall / out_data) returns one word per
//   item with the frame state after that item and, for a read, the entry.
//   A word accepted is shown from the next cycle. Throughput is one item
//   per cycle while the output is not stalled; the width buffer is a
//   single write / single read memory, and the newest entry is mirrored
//   in a register so a merge never has to read the memory. When the
//   receiver stalls, the result word holds and in_stall rises in the same
//   cycle; a word is taken whenever the output slot is free or is being
//   emptied in that cycle. Reset empties the buffer (count to zero, no
//   clearing pass), clears the ready flag, cause, timestamps and counters,
//   and loads the register defaults: capture off, noise 150 us, gap
//   25000 us, 20 pulses. The user writes configuration (cfg_write /
//   cfg_index / cfg_data) only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module ook_pulse_capture_framer #(
  parameter int BUFFER_DEPTH = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ookpcf_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ookpcf_pkg::out_word_t out_data,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  // Configuration registers
  logic        capture_enable;
  logic [15:0] noise_limit_us;
  logic [14:0] gap_limit_us;
  logic [9:0]  min_frame_pulses;

  // Frame state
  logic [CW-1:0]      stored_count, stored_count_next;
  logic               ready_flag, ready_flag_next;
  logic [31:0]        last_edge_time, last_edge_time_next;
  logic               last_level_seen, last_level_seen_next;
  logic [1:0]         cause_reg, cause_reg_next;
  logic [31:0]        glitch_counter, glitch_counter_next;
  logic [31:0]        merge_counter, merge_counter_next;
  logic signed [15:0] top_entry, top_entry_next;

  // Width buffer
  logic [15:0]   pulse_store [BUFFER_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   rd_data;
  logic          rd_hit, rd_hit_next;

  logic accept;

  // Handshake: take a word when the result slot is free or being emptied
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enable   <= 1'b0;
      noise_limit_us   <= ookpcf_pkg::NOISE_LIMIT_RESET;
      gap_limit_us     <= ookpcf_pkg::FRAME_GAP_RESET;
      min_frame_pulses <= ookpcf_pkg::MIN_PULSES_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ookpcf_pkg::REG_CAPTURE_ENABLE:   capture_enable   <= cfg_data[0];
        ookpcf_pkg::REG_NOISE_LIMIT_US:   noise_limit_us   <= cfg_data;
        ookpcf_pkg::REG_FRAME_GAP_US:     gap_limit_us     <= cfg_data[14:0];
        ookpcf_pkg::REG_MIN_FRAME_PULSES: min_frame_pulses <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Work out the state after one item
  always_comb begin
    logic [31:0]        dur;
    logic               enough;
    logic signed [16:0] mag;
    logic signed [16:0] width;
    logic               width_pos;
    logic               top_pos;
    logic signed [16:0] sum;
    logic signed [15:0] sat;
    logic [CW-1:0]      cnt_after;

    stored_count_next    = stored_count;
    ready_flag_next      = ready_flag;
    last_edge_time_next  = last_edge_time;
    last_level_seen_next = last_level_seen;
    cause_reg_next       = cause_reg;
    glitch_counter_next  = glitch_counter;
    merge_counter_next   = merge_counter;
    top_entry_next       = top_entry;
    mem_we               = 1'b0;
    mem_waddr            = stored_count[AW-1:0];
    mem_wdata            = 16'd0;
    rd_hit_next          = 1'b0;

    dur       = in_data.time_us - last_edge_time;
    enough    = 32'(stored_count) >= 32'(min_frame_pulses);
    mag       = $signed({2'b00, dur[14:0]});
    width     = last_level_seen ? mag : -mag;
    width_pos = last_level_seen && (dur != 32'd0);
    top_pos   = top_entry > 16'sd0;
    sum       = 17'(top_entry) + width;
    if (sum > ookpcf_pkg::WIDTH_MAX) begin
      sat = 16'sd32767;
    end else if (sum < ookpcf_pkg::WIDTH_MIN) begin
      sat = -16'sd32768;
    end else begin
      sat = sum[15:0];
    end
    cnt_after = stored_count;

    case (in_data.mode)
      ookpcf_pkg::MODE_EDGE: begin
        if (capture_enable) begin
          if (dur < 32'(noise_limit_us)) begin
            glitch_counter_next = glitch_counter + 32'd1;
          end else if (!ready_flag) begin
            last_edge_time_next  = in_data.time_us;
            last_level_seen_next = in_data.level;
            if (dur > 32'(gap_limit_us)) begin
              // Long gap: close a big enough frame, drop a short one
              if (enough) begin
                ready_flag_next = 1'b1;
                cause_reg_next  = ookpcf_pkg::CAUSE_GAP;
              end else begin
                stored_count_next = '0;
              end
            end else if (32'(stored_count) < BUFFER_DEPTH) begin
              if (stored_count != '0 && top_pos == width_pos) begin
                // Same sign: merge into the newest entry
                mem_we             = 1'b1;
                mem_waddr          = AW'(stored_count - CW'(1));
                mem_wdata          = sat;
                top_entry_next     = sat;
                merge_counter_next = merge_counter + 32'd1;
              end else begin
                // Append a new entry
                mem_we            = 1'b1;
                mem_waddr         = stored_count[AW-1:0];
                mem_wdata         = width[15:0];
                top_entry_next    = width[15:0];
                cnt_after         = stored_count + CW'(1);
                stored_count_next = cnt_after;
              end
              if (32'(cnt_after) >= BUFFER_DEPTH) begin
                ready_flag_next = 1'b1;
                cause_reg_next  = ookpcf_pkg::CAUSE_FULL;
              end
            end
          end
        end
      end
      ookpcf_pkg::MODE_TCHECK: begin
        if (!ready_flag && enough && dur > 32'(gap_limit_us)) begin
          ready_flag_next = 1'b1;
          cause_reg_next  = ookpcf_pkg::CAUSE_TIMEOUT;
        end
      end
      ookpcf_pkg::MODE_RELEASE: begin
        stored_count_next    = '0;
        ready_flag_next      = 1'b0;
        last_edge_time_next  = in_data.time_us;
        last_level_seen_next = in_data.level;
        cause_reg_next       = ookpcf_pkg::CAUSE_NONE;
      end
      default: begin
        rd_hit_next = (32'(in_data.read_index) < 32'(stored_count)) &&
                      (32'(in_data.read_index) < BUFFER_DEPTH);
      end
    endcase
  end

  assign mem_raddr = AW'(32'(in_data.read_index));

  // Width buffer: at most one write and one registered read per cycle, only for an accepted word
  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      pulse_store[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_data <= pulse_store[mem_raddr];
    end
  end

  // Advance frame state and the result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count    <= '0;
      ready_flag      <= 1'b0;
      last_edge_time  <= 32'd0;
      last_level_seen <= 1'b0;
      cause_reg       <= ookpcf_pkg::CAUSE_NONE;
      glitch_counter  <= 32'd0;
      merge_counter   <= 32'd0;
      rd_hit          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        stored_count    <= stored_count_next;
        ready_flag      <= ready_flag_next;
        last_edge_time  <= last_edge_time_next;
        last_level_seen <= last_level_seen_next;
        cause_reg       <= cause_reg_next;
        glitch_counter  <= glitch_counter_next;
        merge_counter   <= merge_counter_next;
        rd_hit          <= rd_hit_next;
        out_valid       <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Mirror of the newest entry, loaded on every write
  always_ff @(posedge clk) begin
    if (accept) begin
      top_entry <= top_entry_next;
    end
  end

  // Drive the result word from the state registers
  always_comb begin
    logic [31:0] cnt_ext;
    cnt_ext                = 32'(stored_count);
    out_data.frame_ready   = ready_flag;
    out_data.pulse_count   = cnt_ext[9:0];
    out_data.read_value    = rd_hit ? $signed(rd_data) : 16'sd0;
    out_data.end_cause     = cause_reg;
    out_data.glitch_total  = glitch_counter;
    out_data.merge_total   = merge_counter;
  end

`ifndef NO_ASSERTIONS
  // A held frame always has a cause, and only a held frame has one
  a_ready_cause : assert property (@(posedge clk) disable iff (rst)
    ready_flag == (cause_reg != ookpcf_pkg::CAUSE_NONE))
    else $error("ready flag and end cause disagree");

  // The count never passes the buffer depth
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    32'(stored_count) <= BUFFER_DEPTH)
    else $error("stored count beyond buffer depth");

  // An empty result slot never holds off the input
  a_no_idle_stall : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result slot");

  // The glitch counter moves by at most one per cycle
  a_glitch_step : assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (glitch_counter - $past(glitch_counter) == 32'd0 ||
                     glitch_counter - $past(glitch_counter) == 32'd1))
    else $error("glitch counter jumped");

  // State holds while no word is accepted
  a_state_hold : assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(stored_count) && $stable(ready_flag))
    else $error("frame state changed without an accepted word");
`endif

endmodule

// ===== tb/sv/tb_ook_pulse_capture_framer.sv =====
// ----------------------------------------------------------------------------
// OOK pulse capture framer testbench
// Drives edge, time check, release and read words through the valid / stall
// channels with random gaps and stalls. A scoreboard tracks the width buffer,
// frame flags and counters of the framer and checks every result word field
// by field. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_ook_pulse_capture_framer;

  localparam int DEPTH = 512;

  typedef struct {
    bit        enable;
    bit [15:0] noise;
    bit [14:0] gap;
    bit [9:0]  min_pulses;
  } capture_cfg_t;

  // Tracks the framer state and holds the result words still to come
  class frame_scoreboard;
    logic signed [15:0]    widths [DEPTH];
    int unsigned           held;
    bit                    ready;
    bit          [31:0]    last_time;
    bit                    last_level;
    logic        [1:0]     cause;
    bit          [31:0]    glitches;
    bit          [31:0]    merges;
    bit                    enable;
    bit          [15:0]    noise_floor;
    bit          [14:0]    gap_us;
    bit          [9:0]     min_pulses;
    ookpcf_pkg::out_word_t expected_words [$];
    int                    errors;

    function new();
      foreach (widths[i]) widths[i] = '0;
      held        = 0;
      ready       = 1'b0;
      last_time   = '0;
      last_level  = 1'b0;
      cause       = ookpcf_pkg::CAUSE_NONE;
      glitches    = '0;
      merges      = '0;
      enable      = 1'b0;
      noise_floor = ookpcf_pkg::NOISE_LIMIT_RESET;
      gap_us      = ookpcf_pkg::FRAME_GAP_RESET;
      min_pulses  = ookpcf_pkg::MIN_PULSES_RESET;
      errors      = 0;
    endfunction

    function void load_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        ookpcf_pkg::REG_CAPTURE_ENABLE:   enable      = data[0];
        ookpcf_pkg::REG_NOISE_LIMIT_US:   noise_floor = data;
        ookpcf_pkg::REG_FRAME_GAP_US:     gap_us      = data[14:0];
        ookpcf_pkg::REG_MIN_FRAME_PULSES: min_pulses  = data[9:0];
        default: ;
      endcase
    endfunction

    // Turn one receiver edge into a stored, merged or dropped width
    function void apply_edge(bit [31:0] t, bit lvl);
      bit [31:0] span;
      int        width;
      int        sum;
      if (!enable) return;
      span = t - last_time;
      if (span < noise_floor) begin
        glitches++;
        return;
      end
      if (ready) return;
      last_time = t;
      // long idle: close the frame or drop a short one
      if (span > gap_us) begin
        if (held >= min_pulses) begin
          ready = 1'b1;
          cause = ookpcf_pkg::CAUSE_GAP;
        end else begin
          held = 0;
        end
        last_level = lvl;
        return;
      end
      if (held < DEPTH) begin
        width = last_level ? int'(span) : -int'(span);
        // a zero width counts as non-positive
        if (held > 0 && ((widths[held-1] > 0) == (width > 0))) begin
          sum = widths[held-1] + width;
          if (sum > ookpcf_pkg::WIDTH_MAX) sum = ookpcf_pkg::WIDTH_MAX;
          if (sum < ookpcf_pkg::WIDTH_MIN) sum = ookpcf_pkg::WIDTH_MIN;
          widths[held-1] = sum[15:0];
          merges++;
        end else begin
          widths[held] = width[15:0];
          held++;
        end
        if (held >= DEPTH) begin
          ready = 1'b1;
          cause = ookpcf_pkg::CAUSE_FULL;
        end
      end
      last_level = lvl;
    endfunction

    function void note_word(ookpcf_pkg::in_word_t w);
      ookpcf_pkg::out_word_t want;
      bit [31:0]             idle;
      want.read_value = '0;
      case (w.mode)
        ookpcf_pkg::MODE_EDGE: apply_edge(w.time_us, w.level);
        ookpcf_pkg::MODE_TCHECK: begin
          idle = w.time_us - last_time;
          if (!ready && held >= min_pulses && idle > gap_us) begin
            ready = 1'b1;
            cause = ookpcf_pkg::CAUSE_TIMEOUT;
          end
        end
        ookpcf_pkg::MODE_RELEASE: begin
          held       = 0;
          ready      = 1'b0;
          last_time  = w.time_us;
          last_level = w.level;
          cause      = ookpcf_pkg::CAUSE_NONE;
        end
        default: begin
          if (w.read_index < held) want.read_value = widths[w.read_index];
        end
      endcase
      want.frame_ready  = ready;
      want.pulse_count  = held[9:0];
      want.end_cause    = cause;
      want.glitch_total = glitches;
      want.merge_total  = merges;
      expected_words.push_back(want);
    endfunction

    function void check_word(ookpcf_pkg::out_word_t got);
      ookpcf_pkg::out_word_t want;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (got.frame_ready !== want.frame_ready) begin
        $error("frame_ready: expected %0d, got %0d", want.frame_ready, got.frame_ready);
        errors++;
      end
      if (got.pulse_count !== want.pulse_count) begin
        $error("pulse_count: expected %0d, got %0d", want.pulse_count, got.pulse_count);
        errors++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
        errors++;
      end
      if (got.end_cause !== want.end_cause) begin
        $error("end_cause: expected %0d, got %0d", want.end_cause, got.end_cause);
        errors++;
      end
      if (got.glitch_total !== want.glitch_total) begin
        $error("glitch_total: expected %0d, got %0d", want.glitch_total, got.glitch_total);
        errors++;
      end
      if (got.merge_total !== want.merge_total) begin
        $error("merge_total: expected %0d, got %0d", want.merge_total, got.merge_total);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  ookpcf_pkg::in_word_t  in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  ookpcf_pkg::out_word_t out_data;
  logic                  cfg_write = 1'b0;
  logic [1:0]            cfg_index = ookpcf_pkg::REG_CAPTURE_ENABLE;
  logic [15:0]           cfg_data  = '0;

  frame_scoreboard frames = new();
  capture_cfg_t    cur;
  bit   [31:0]     cursor;
  bit              tx_burst;
  bit              rx_burst;
  bit              held_off;
  int              words_sent;
  int              words_seen;

  always #1 clk = ~clk;

  ook_pulse_capture_framer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(logic [1:0] mode, logic [31:0] t, logic lvl, logic [8:0] idx);
    ookpcf_pkg::in_word_t w;
    int unsigned          pause;
    w.mode       = mode;
    w.time_us    = t;
    w.level      = lvl;
    w.read_index = idx;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    pause = tx_burst ? 0 : $urandom_range(0, 8);
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    frames.note_word(w);
    words_sent++;
  endtask

  task automatic send_edge(int unsigned dur, bit lvl);
    cursor = cursor + dur;
    send_word(ookpcf_pkg::MODE_EDGE, cursor, lvl, 9'($urandom_range(0, 511)));
  endtask

  task automatic send_check(int unsigned dur);
    send_word(ookpcf_pkg::MODE_TCHECK, cursor + dur, 1'($urandom_range(0, 1)),
              9'($urandom_range(0, 511)));
  endtask

  task automatic send_release(bit lvl);
    send_word(ookpcf_pkg::MODE_RELEASE, cursor, lvl, 9'($urandom_range(0, 511)));
  endtask

  task automatic send_read(int unsigned idx);
    send_word(ookpcf_pkg::MODE_READ, $urandom, 1'($urandom_range(0, 1)), 9'(idx));
  endtask

  // Drop valid and wait for every pending result word
  task automatic settle();
    in_valid <= 1'b0;
    while (frames.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic poke_reg(logic [1:0] idx, logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    frames.load_reg(idx, data);
  endtask

  task automatic apply_config(bit en, int unsigned noise, int unsigned gap, int unsigned minp);
    settle();
    cur.enable     = en;
    cur.noise      = 16'(noise);
    cur.gap        = 15'(gap);
    cur.min_pulses = 10'(minp);
    poke_reg(ookpcf_pkg::REG_CAPTURE_ENABLE, {15'd0, cur.enable});
    poke_reg(ookpcf_pkg::REG_NOISE_LIMIT_US, cur.noise);
    poke_reg(ookpcf_pkg::REG_FRAME_GAP_US, {1'b0, cur.gap});
    poke_reg(ookpcf_pkg::REG_MIN_FRAME_PULSES, {6'd0, cur.min_pulses});
    cfg_write <= 1'b0;
  endtask

  // Take result words with random stalls and one long hold-off
  initial begin : drain_results
    int unsigned hold;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      hold = rx_burst ? 0 : $urandom_range(0, 8);
      if (!held_off && words_seen >= 150) begin
        hold     = 64;
        held_off = 1'b1;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      frames.check_word(out_data);
      words_seen++;
    end
  end

  initial begin : run_stimulus
    int unsigned lo;
    int unsigned hi;
    int unsigned r;
    int unsigned phase_len;
    bit          lvl;
    cur.enable     = 1'b0;
    cur.noise      = ookpcf_pkg::NOISE_LIMIT_RESET;
    cur.gap        = ookpcf_pkg::FRAME_GAP_RESET;
    cur.min_pulses = ookpcf_pkg::MIN_PULSES_RESET;
    cursor = $urandom;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // capture still off after reset: edge ignored, empty read
    send_edge(500, 1'b1);
    send_read(0);

    // zero widths, saturating merges, time wrap, gap close, ignore while ready
    apply_config(1'b1, 0, 32767, 2);
    cursor = 32'hFFFF_F000;
    send_release(1'b1);
    send_edge(0, 1'b0);
    send_edge(30000, 1'b0);
    send_edge(30000, 1'b1);
    send_edge(32767, 1'b1);
    send_edge(20000, 1'b0);
    send_read(0);
    send_read(1);
    send_read(2);
    send_read(511);
    send_edge(32768, 1'b1);
    send_edge(100, 1'b0);
    send_check(40000);
    send_release(1'b0);

    // widest noise limit, zero gap and zero pulse minimum; glitch while ready
    apply_config(1'b1, 16'hFFFF, 0, 0);
    send_edge(10, 1'b0);
    send_edge(65535, 1'b1);
    send_edge(5, 1'b0);
    send_release(1'b1);

    // timeout close by a time check
    apply_config(1'b1, 100, 1000, 2);
    send_edge(500, 1'b0);
    send_edge(600, 1'b1);
    send_check(1001);
    send_read(1);
    send_release(1'b0);

    // fill the whole buffer with short alternating widths
    apply_config(1'b1, 1, 32767, 512);
    lvl = 1'b1;
    send_release(lvl);
    for (int i = 0; i < 560; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        send_read($urandom_range(0, 511));
      end else begin
        if ($urandom_range(0, 31) != 0) lvl = !lvl;
        send_edge($urandom_range(0, 60), lvl);
      end
    end
    send_read(511);
    send_read(0);
    send_check(40000);
    send_edge(200, !lvl);
    send_release(lvl);

    // random phases of mostly well-formed pulse trains
    while (words_sent < 1300) begin
      r  = $urandom_range(0, 9);
      lo = (r == 0) ? 0 : (r == 1) ? 16'hFFFF : $urandom_range(1, 400);
      r  = $urandom_range(0, 9);
      hi = (r == 0) ? 0 : (r == 1) ? 15'h7FFF : $urandom_range(300, 20000);
      r  = $urandom_range(0, 9);
      apply_config($urandom_range(0, 9) != 0, lo, hi,
                   (r == 0) ? 0 : (r == 1) ? 512 : $urandom_range(1, 30));
      phase_len = $urandom_range(20, 80);
      if ($urandom_range(0, 1) == 0) begin
        cursor = cursor + $urandom_range(0, 70000);
        send_release(lvl);
      end
      for (int i = 0; i < phase_len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 66) begin
          lo = 32'(cur.noise);
          hi = (cur.gap > cur.noise) ? 32'(cur.gap) : 32'(cur.noise);
          if (hi > lo + 3000) hi = lo + 3000;
          if ($urandom_range(0, 7) != 0) lvl = !lvl;
          send_edge($urandom_range(lo, hi), lvl);
        end else if (r < 72) begin
          lo = (cur.noise > 0) ? $urandom_range(0, cur.noise - 1) : 0;
          send_word(ookpcf_pkg::MODE_EDGE, cursor + lo, 1'($urandom_range(0, 1)),
                    9'($urandom_range(0, 511)));
        end else if (r < 77) begin
          lvl = !lvl;
          send_edge(cur.gap + 1 + $urandom_range(0, 4000), lvl);
        end else if (r < 83) begin
          send_check($urandom_range(0, cur.gap + 2000));
        end else if (r < 86) begin
          cursor = cursor + $urandom_range(0, 70000);
          lvl    = 1'($urandom_range(0, 1));
          send_release(lvl);
        end else if (r < 96) begin
          send_read(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                : $urandom_range(0, 40));
        end else begin
          send_word(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
                    9'($urandom_range(0, 511)));
        end
      end
    end

    settle();
    if (frames.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
sv/ookpcf_pkg.sv
sv/ook_pulse_capture_framer.sv
tb/sv/tb_ook_pulse_capture_framer.sv
